// ===== src/sdsr_pkg.sv =====
// ----------------------------------------------------------------------------
// sdsr_pkg
// Shared types and constants of the square and twice-square range counter.
// ----------------------------------------------------------------------------
package sdsr_pkg;

  // result fields
  localparam int COUNT_W = 21;
  localparam int OUT_W   = 24;

  // operand selection for the shared root unit
  localparam logic [1:0] OP_HI      = 2'd0;
  localparam logic [1:0] OP_HI_HALF = 2'd1;
  localparam logic [1:0] OP_LO      = 2'd2;
  localparam logic [1:0] OP_LO_HALF = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       load;
    logic [1:0] op_sel;
    logic       step;
    logic       accum;
    logic       acc_sub;
    logic       out_load;
  } sdsr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic range_err;
  } sdsr_status_t;

endpackage

// ===== src/sdsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdsr_ctrl
// Sequencer: captures a transaction, runs four roots through the shared
// unit unless the range is invalid, and hands the result to the output register.
// ----------------------------------------------------------------------------
module sdsr_ctrl #(
  parameter int ROOT_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output sdsr_pkg::sdsr_cmd_t    cmd,
  input  sdsr_pkg::sdsr_status_t status
);
  import sdsr_pkg::*;

  localparam int CNT_W = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_ROOT  = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       op_r, op_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.op_sel    = op_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.range_err) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.load   = 1'b1;
          cmd.op_sel = OP_HI;
          op_nxt     = OP_HI;
          cnt_nxt    = CNT_W'(ROOT_BITS - 1);
          state_nxt  = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_ACC;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_ACC: begin
        cmd.accum   = 1'b1;
        // roots of the low bound are taken away
        cmd.acc_sub = (op_r inside {OP_LO, OP_LO_HALF});
        if (op_r == OP_LO_HALF) begin
          state_nxt = ST_DONE;
        end else begin
          // next operand loads while this root is folded in
          cmd.load   = 1'b1;
          cmd.op_sel = op_r + 2'd1;
          op_nxt     = op_r + 2'd1;
          cnt_nxt    = CNT_W'(ROOT_BITS - 1);
          state_nxt  = ST_ROOT;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      op_r        <= OP_HI;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/sdsr_dpath.sv =====
// ----------------------------------------------------------------------------
// sdsr_dpath
// Bound registers, one digit-by-digit square root unit (one root bit per
// cycle), add/subtract accumulator and output register.
// ----------------------------------------------------------------------------
module sdsr_dpath #(
  parameter int VALUE_BITS = 40
) (
  input  logic                   clk,
  input  logic [VALUE_BITS-1:0]  range_low,
  input  logic [VALUE_BITS-1:0]  range_high,
  input  sdsr_pkg::sdsr_cmd_t     cmd,
  output sdsr_pkg::sdsr_status_t  status,
  output logic [sdsr_pkg::COUNT_W-1:0] count,
  output logic                   range_error
);
  import sdsr_pkg::*;

  localparam int RB    = (VALUE_BITS + 1) / 2;
  localparam int X_W   = 2 * RB;
  localparam int RW    = RB + 2;
  localparam int ACC_W = (RB + 1 > COUNT_W) ? RB + 1 : COUNT_W;

  logic [VALUE_BITS-1:0] hi_r, lo_m1_r;
  logic                  err_r;
  logic [X_W-1:0]        x_r;
  logic [RW-1:0]         rem_r;
  logic [RB-1:0]         q_r;
  logic [ACC_W-1:0]      acc_r;
  logic [COUNT_W-1:0]    out_count_r;
  logic                  out_err_r;

  logic [VALUE_BITS-1:0] operand;
  logic [RW-1:0]         rem_sh, trial;
  logic                  ge;
  logic [ACC_W-1:0]      q_ext;

  always_comb begin
    case (cmd.op_sel)
      OP_HI:      operand = hi_r;
      OP_HI_HALF: operand = hi_r >> 1;
      OP_LO:      operand = lo_m1_r;
      OP_LO_HALF: operand = lo_m1_r >> 1;
      default:    operand = hi_r;
    endcase
  end

  // bring down the next two operand bits and try a one in this root bit
  assign rem_sh = {rem_r[RW-3:0], x_r[X_W-1 -: 2]};
  assign trial  = {q_r, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign q_ext  = ACC_W'(q_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hi_r    <= range_high;
      lo_m1_r <= range_low - 1'b1;
      err_r   <= (range_low == '0) || (range_low > range_high);
      acc_r   <= '0;
    end else if (cmd.accum) begin
      if (cmd.acc_sub) begin
        acc_r <= acc_r - q_ext;
      end else begin
        acc_r <= acc_r + q_ext;
      end
    end
    if (cmd.load) begin
      x_r   <= X_W'(operand);
      rem_r <= '0;
      q_r   <= '0;
    end else if (cmd.step) begin
      x_r   <= x_r << 2;
      rem_r <= ge ? (rem_sh - trial) : rem_sh;
      q_r   <= {q_r[RB-2:0], ge};
    end
    if (cmd.out_load) begin
      out_count_r <= acc_r[COUNT_W-1:0];
      out_err_r   <= err_r;
    end
  end

  assign status.range_err = err_r;
  assign count            = out_count_r;
  assign range_error      = out_err_r;

endmodule

// ===== src/square_and_double_square_range_count_core.sv =====
// sequence: capture, then range check; an invalid range goes straight to the
//   output register, otherwise four roots of ROOT_BITS = (VALUE_BITS+1)/2 bits come first
// throughput: one transaction at a time; the shared
//   square root unit settles one root bit per cycle for each of four roots
// reset: synchronous active-low rst_n clears the sequencer and output valid
// ----------------------------------------------------------------------------
// square_and_double_square_range_count_core
// Counts squares and twice-squares in an inclusive range by four floor
// square roots on one shared unit.
// ----------------------------------------------------------------------------
module square_and_double_square_range_count_core #(
  parameter int VALUE_BITS = 40
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // range_low, range_high, zero fill to whole bytes
  input  logic [((2*VALUE_BITS+7)/8)*8-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // count[20:0], range_error[21], zero fill [23:22]
  output logic [sdsr_pkg::OUT_W-1:0]     out_tdata
);
  import sdsr_pkg::*;

  localparam int RB = (VALUE_BITS + 1) / 2;

  sdsr_cmd_t          cmd;
  sdsr_status_t       status;
  logic [COUNT_W-1:0] count;
  logic               range_error;

  sdsr_ctrl #(
    .ROOT_BITS(RB)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .status    (status)
  );

  sdsr_dpath #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dpath (
    .clk        (clk),
    .range_low  (in_tdata[VALUE_BITS-1:0]),
    .range_high (in_tdata[2*VALUE_BITS-1:VALUE_BITS]),
    .cmd        (cmd),
    .status     (status),
    .count      (count),
    .range_error(range_error)
  );

  assign out_tdata = {{(OUT_W-COUNT_W-1){1'b0}}, range_error, count};

`ifndef ASSERT_OFF
  // an error result never carries a count
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[COUNT_W] |-> out_tdata[COUNT_W-1:0] == '0)
    else $error("error result with nonzero count");

  // one item in flight: no second accept right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // output register only reloads when empty or being drained
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("output register overwritten while stalled");
`endif

endmodule
